/* sv/moving_average_filter_defines.svh */
// assertion macros shared by the moving average filter modules
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef MOVING_AVERAGE_FILTER_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MAF_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("maf assertion failed");
`define MAF_IMPLIES(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("maf assertion failed");
`else
`define MAF_ASSERT(lbl, cond)
`define MAF_IMPLIES(lbl, pre, post)
`endif

`endif

/* sv/maf_pkg.sv */
// shared constants and types for the moving average filter
// no dependencies
package maf_pkg;

    localparam int MAX_WINDOW_DEF   = 1024;
    localparam int SAMPLE_WIDTH_DEF = 14;
    localparam int CFG_WIDTH        = 11;
    localparam int QUEUE_DEPTH      = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

/* sv/maf_ram.sv */
// generic single write port ram with registered read
// no dependencies
module maf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/maf_front.sv */
// front end: takes sample beats, keeps the ring and running sum, queues work
// depends on maf_pkg, maf_ram and moving_average_filter_defines.svh
`include "moving_average_filter_defines.svh"
module maf_front import maf_pkg::*; #(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int POS_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    parameter int WIN_W        = $clog2(MAX_WINDOW + 1),
    parameter int SUM_W        = SAMPLE_WIDTH + $clog2(MAX_WINDOW),
    parameter int ENTRY_W      = 1 + SAMPLE_WIDTH + SUM_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic [WIN_W-1:0]               i_win,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                           i_restart,
    input  t_queue_stat                    i_qstat,
    output logic                           o_push,
    output logic [ENTRY_W-1:0]             o_entry
);

    logic                           r_s1_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_sample;
    logic [POS_W-1:0]               r_wpos;
    logic signed [SUM_W-1:0]        r_sum;
    logic                           r_filled;

    logic                           accept;
    logic                           active;
    logic                           push;
    logic                           last;
    logic [POS_W-1:0]               rd_addr;
    logic [SAMPLE_WIDTH-1:0]        rd_data;
    logic signed [SAMPLE_WIDTH-1:0] old_sample;
    logic signed [SUM_W-1:0]        n_sum;
    logic                           n_filled;

    assign accept  = i_valid && !r_s1_valid;
    assign active  = (i_win != '0);
    assign push    = r_s1_valid && !i_qstat.full;
    assign rd_addr = i_restart ? '0 : r_wpos;

    maf_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW),
        .AW    (POS_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (push && active),
        .i_waddr (r_wpos),
        .i_wdata (r_s1_sample),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // entries not yet written since the last clear read as zero
    assign old_sample = r_filled ? $signed(rd_data) : '0;
    assign n_sum      = r_sum - SUM_W'(old_sample) + SUM_W'(r_s1_sample);
    assign last       = (WIN_W'(r_wpos) == (i_win - WIN_W'(1)));
    assign n_filled   = r_filled || last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wpos     <= '0;
            r_sum      <= '0;
            r_filled   <= 1'b0;
        end else begin
            if (i_clear || (accept && i_restart)) begin
                r_wpos   <= '0;
                r_sum    <= '0;
                r_filled <= 1'b0;
            end else if (push && active) begin
                r_sum    <= n_sum;
                r_filled <= n_filled;
                r_wpos   <= last ? '0 : r_wpos + POS_W'(1);
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample <= i_sample_in;
        end
    end

    assign o_stall = r_s1_valid;
    assign o_push  = push;
    assign o_entry = {active && n_filled, r_s1_sample, n_sum};

    `MAF_IMPLIES(a_wpos_in_window, i_win != '0, WIN_W'(r_wpos) < i_win)
    `MAF_IMPLIES(a_filled_needs_window, r_filled, i_win != '0)

endmodule

/* sv/maf_fifo.sv */
// short queue between front and back end
// depends on maf_pkg and moving_average_filter_defines.svh
`include "moving_average_filter_defines.svh"
module maf_fifo import maf_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_queue_stat      o_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    `MAF_IMPLIES(a_no_push_when_full, i_push, !o_stat.full)
    `MAF_IMPLIES(a_no_pop_when_empty, i_pop, !o_stat.empty)

endmodule

/* sv/maf_back.sv */
// back end: serial divider for the window mean and the output register
// depends on maf_pkg and moving_average_filter_defines.svh
`include "moving_average_filter_defines.svh"
module maf_back import maf_pkg::*; #(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int WIN_W        = $clog2(MAX_WINDOW + 1),
    parameter int SUM_W        = SAMPLE_WIDTH + $clog2(MAX_WINDOW),
    parameter int ENTRY_W      = 1 + SAMPLE_WIDTH + SUM_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [WIN_W-1:0]               i_win,
    input  t_queue_stat                    i_qstat,
    input  logic [ENTRY_W-1:0]             i_entry,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_window_full
);

    localparam int CNT_W = $clog2(SUM_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [WIN_W-1:0]        r_rem;
    logic [SUM_W-1:0]        r_quo;
    logic                    r_neg;
    logic                    r_ovalid;
    logic [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                    r_out_full;

    logic                    e_div;
    logic [SAMPLE_WIDTH-1:0] e_sample;
    logic [SUM_W-1:0]        e_sum;
    logic [SUM_W-1:0]        mag;
    logic                    out_free;
    logic                    out_load;
    logic                    pop;
    logic [WIN_W:0]          trial;
    logic [WIN_W:0]          diff;
    logic                    ge;
    logic [WIN_W-1:0]        n_rem;
    logic [SUM_W-1:0]        quot;

    assign e_div    = i_entry[ENTRY_W-1];
    assign e_sample = i_entry[SUM_W +: SAMPLE_WIDTH];
    assign e_sum    = i_entry[SUM_W-1:0];
    assign mag      = e_sum[SUM_W-1] ? (SUM_W'(0) - e_sum) : e_sum;

    assign out_free = !r_ovalid || !i_stall;
    assign pop      = (r_state == S_IDLE) && !i_qstat.empty && (e_div || out_free);
    assign out_load = (pop && !e_div) || ((r_state == S_DONE) && out_free);

    // one quotient bit per cycle on the magnitude
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign diff  = trial - {1'b0, i_win};
    assign ge    = (trial >= {1'b0, i_win});
    assign n_rem = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
    assign quot  = r_neg ? (SUM_W'(0) - r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        if (e_div) begin
                            r_state <= S_DIV;
                            r_cnt   <= '0;
                            r_rem   <= '0;
                            r_quo   <= mag;
                            r_neg   <= e_sum[SUM_W-1];
                        end else begin
                            r_out_sample <= e_sample;
                            r_out_full   <= 1'b0;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[SUM_W-2:0], ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(SUM_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_sample <= quot[SAMPLE_WIDTH-1:0];
                        r_out_full   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_pop         = pop;
    assign o_valid       = r_ovalid;
    assign o_sample_out  = $signed(r_out_sample);
    assign o_window_full = r_out_full;

    `MAF_IMPLIES(a_div_nonzero_window, r_state == S_DIV, i_win != '0)

endmodule

/* sv/moving_average_filter.sv */
// path: the front end registers a beat and queues it; the back end loads pass-through and filling
// beats straight into the output register, averaged beats after the one-bit-per-cycle divider
// flow: front end takes no new beat until the last one is pushed to the queue (ring read, then update);
// the back end takes no new entry while a divide runs or waits for the output register
// reset: synchronous active low; window length 0, sum, position and fill flag cleared,
// no clearing pass: ring entries beyond the fill point read as zero
module moving_average_filter import maf_pkg::*; #(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_WIDTH-1:0]           i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                           i_restart,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_window_full
);

    localparam int POS_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
    localparam int ENTRY_W = 1 + SAMPLE_WIDTH + SUM_W;

    logic [CFG_WIDTH-1:0] r_wlen;
    logic                 cfg_we;
    logic [WIN_W-1:0]     eff_win;
    logic                 push;
    logic                 pop;
    logic [ENTRY_W-1:0]   push_entry;
    logic [ENTRY_W-1:0]   pop_entry;
    t_queue_stat          qstat;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= '0;
        end else if (cfg_we) begin
            r_wlen <= i_cfg_data;
        end
    end

    // window length saturates at the ring depth
    assign eff_win = (32'(r_wlen) > 32'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : WIN_W'(r_wlen);

    maf_front #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .POS_W        (POS_W),
        .WIN_W        (WIN_W),
        .SUM_W        (SUM_W),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cfg_we),
        .i_win       (eff_win),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample_in (i_sample_in),
        .i_restart   (i_restart),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    maf_fifo #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (pop_entry),
        .o_stat  (qstat)
    );

    maf_back #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .WIN_W        (WIN_W),
        .SUM_W        (SUM_W),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_win         (eff_win),
        .i_qstat       (qstat),
        .i_entry       (pop_entry),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample_out  (o_sample_out),
        .o_window_full (o_window_full)
    );

endmodule
